// File: design/assert_macros.svh
// Assertion macros shared by the packet sender modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// File: design/ps2cps_pkg.sv
// Types and constants for the PS/2 command packet sender.
package ps2cps_pkg;

	localparam int MAX_PACKET_BYTES = 16;
	localparam int IDX_W            = $clog2(MAX_PACKET_BYTES);
	localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] RESEND_CODE_RST  = 8'd254;
	localparam logic [7:0] NACK_CODE_RST    = 8'd252;
	localparam logic [7:0] MOUSE_PREFIX_RST = 8'd212;
	localparam logic [7:0] RESEND_LIMIT_RST = 8'd3;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_REPLY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_RESEND_LIMIT = 2'd0,
		CFG_RESEND_CODE  = 2'd1,
		CFG_NACK_CODE    = 2'd2,
		CFG_MOUSE_PREFIX = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_PROGRESS = 3'd0,
		ST_SUCCESS  = 3'd1,
		ST_TIMEOUT  = 3'd2,
		ST_DEVERR   = 3'd3,
		ST_BUSY     = 3'd4,
		ST_IDLE     = 3'd5
	} status_t;

	// One queued job: either a completion report or an optional prefix plus a data byte.
	typedef struct packed {
		logic       done;
		status_t    status;
		logic       prefix_en;
		logic [7:0] prefix;
		logic [7:0] data;
	} job_t;

endpackage

// File: design/ps2cps_front.sv
// Front end: accepts items, holds packet state and store, classifies each item into a job.
module ps2cps_front
	import ps2cps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       operation,
	input  logic [IDX_W-1:0] byte_index,
	input  logic [7:0]       packet_byte,
	input  logic [4:0]       packet_length,
	input  logic             to_mouse,
	input  logic [7:0]       device_reply,
	input  logic             link_ready,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output logic             push,
	output job_t             job
);

	logic             sending_q;
	logic [POS_W-1:0] next_pos_q;
	logic [POS_W-1:0] active_len_q;
	logic [8:0]       resend_cnt_q;
	logic             mouse_tgt_q;
	logic [7:0]       resend_limit_q;
	logic [7:0]       resend_code_q;
	logic [7:0]       nack_code_q;
	logic [7:0]       mouse_prefix_q;
	logic [7:0]       store_q [MAX_PACKET_BYTES];

	logic             sending_d;
	logic [POS_W-1:0] next_pos_d;
	logic [POS_W-1:0] active_len_d;
	logic [8:0]       resend_cnt_d;
	logic             mouse_tgt_d;
	logic [POS_W-1:0] plen_clamp;
	logic [POS_W-1:0] pos_sel;
	logic [8:0]       resend_inc;
	logic             do_send;

	always_comb begin
		if (packet_length == 5'd0) begin
			plen_clamp = POS_W'(1);
		end else if (packet_length > 5'(MAX_PACKET_BYTES)) begin
			plen_clamp = POS_W'(MAX_PACKET_BYTES);
		end else begin
			plen_clamp = POS_W'(packet_length);
		end
	end

	assign resend_inc = (resend_cnt_q == 9'd511) ? resend_cnt_q : resend_cnt_q + 9'd1;

	always_comb begin
		sending_d     = sending_q;
		next_pos_d    = next_pos_q;
		active_len_d  = active_len_q;
		resend_cnt_d  = resend_cnt_q;
		mouse_tgt_d   = mouse_tgt_q;
		push          = 1'b0;
		do_send       = 1'b0;
		pos_sel       = next_pos_q;
		job.done      = 1'b1;
		job.status    = ST_PROGRESS;
		job.prefix_en = 1'b0;
		job.prefix    = mouse_prefix_q;
		job.data      = 8'd0;
		unique case (operation)
			OP_START: begin
				push = 1'b1;
				if (sending_q) begin
					job.status = ST_BUSY;
				end else begin
					mouse_tgt_d  = to_mouse;
					active_len_d = plen_clamp;
					pos_sel      = '0;
					do_send      = 1'b1;
				end
			end
			OP_REPLY: begin
				push = 1'b1;
				if (!sending_q) begin
					job.status = ST_IDLE;
				end else if (device_reply == resend_code_q) begin
					if (resend_inc > {1'b0, resend_limit_q}) begin
						sending_d    = 1'b0;
						resend_cnt_d = '0;
						job.status   = ST_TIMEOUT;
					end else begin
						resend_cnt_d = resend_inc;
						pos_sel      = (next_pos_q != '0) ? next_pos_q - POS_W'(1) : next_pos_q;
						do_send      = 1'b1;
					end
				end else if (device_reply == nack_code_q) begin
					sending_d    = 1'b0;
					resend_cnt_d = '0;
					job.status   = ST_DEVERR;
				end else begin
					resend_cnt_d = '0;
					do_send      = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase

		// Send, finish or time out from the chosen position.
		if (do_send) begin
			next_pos_d = pos_sel;
			if (operation == OP_REPLY && pos_sel >= active_len_q) begin
				sending_d  = 1'b0;
				job.status = ST_SUCCESS;
			end else if (!link_ready) begin
				sending_d  = 1'b0;
				job.status = ST_TIMEOUT;
			end else begin
				sending_d     = 1'b1;
				next_pos_d    = pos_sel + POS_W'(1);
				job.done      = 1'b0;
				job.prefix_en = (operation == OP_START) ? to_mouse : mouse_tgt_q;
				job.data      = store_q[pos_sel[IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q    <= 1'b0;
			next_pos_q   <= '0;
			active_len_q <= '0;
			resend_cnt_q <= '0;
			mouse_tgt_q  <= 1'b0;
		end else if (accept) begin
			sending_q    <= sending_d;
			next_pos_q   <= next_pos_d;
			active_len_q <= active_len_d;
			resend_cnt_q <= resend_cnt_d;
			mouse_tgt_q  <= mouse_tgt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_limit_q <= RESEND_LIMIT_RST;
			resend_code_q  <= RESEND_CODE_RST;
			nack_code_q    <= NACK_CODE_RST;
			mouse_prefix_q <= MOUSE_PREFIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RESEND_LIMIT: resend_limit_q <= cfg_data;
				CFG_RESEND_CODE:  resend_code_q  <= cfg_data;
				CFG_NACK_CODE:    nack_code_q    <= cfg_data;
				CFG_MOUSE_PREFIX: mouse_prefix_q <= cfg_data;
				default:          resend_limit_q <= resend_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD) begin
			store_q[byte_index] <= packet_byte;
		end
	end

	`include "assert_macros.svh"

	`CHK_IMPLY(a_active_len_range, sending_q, active_len_q != '0 && active_len_q <= POS_W'(MAX_PACKET_BYTES))

endmodule

// File: design/ps2cps_fifo.sv
// Short job queue between the front end and the result sequencer.
module ps2cps_fifo
	import ps2cps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rd_job
);

	job_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full   = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	`include "assert_macros.svh"

	`CHK_IMPLY(a_no_push_full, full, !push)
	`CHK_IMPLY(a_no_pop_empty, empty, !pop)

endmodule

// File: design/ps2cps_back.sv
// Back end: turns queued jobs into result transactions through an output register.
module ps2cps_back
	import ps2cps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  job_t       rd_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output kind_t      result_kind,
	output logic [7:0] out_byte,
	output status_t    status,
	output logic       last
);

	logic       valid_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	kind_t      kind_q;
	logic [7:0] byte_q;
	status_t    status_q;
	logic       last_q;
	logic       out_free;

	assign out_free    = !valid_q || !out_stall;
	assign pop         = out_free && !pend_q && !empty;
	assign out_valid   = valid_q;
	assign result_kind = kind_q;
	assign out_byte    = byte_q;
	assign status      = status_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !empty;
				pend_q  <= !empty && !rd_job.done && rd_job.prefix_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				kind_q   <= KIND_DATA;
				byte_q   <= pend_byte_q;
				status_q <= ST_PROGRESS;
				last_q   <= 1'b1;
			end else if (rd_job.done) begin
				kind_q   <= KIND_DONE;
				byte_q   <= 8'd0;
				status_q <= rd_job.status;
				last_q   <= 1'b1;
			end else if (rd_job.prefix_en) begin
				// Hold the data byte until the prefix transaction is taken.
				kind_q      <= KIND_CMD;
				byte_q      <= rd_job.prefix;
				status_q    <= ST_PROGRESS;
				last_q      <= 1'b0;
				pend_byte_q <= rd_job.data;
			end else begin
				kind_q   <= KIND_DATA;
				byte_q   <= rd_job.data;
				status_q <= ST_PROGRESS;
				last_q   <= 1'b1;
			end
		end
	end

	`include "assert_macros.svh"

	`CHK_IMPLY(a_pend_has_out, pend_q, valid_q && kind_q == KIND_CMD && !last_q)
	`CHK_IMPLY(a_not_last_is_prefix, valid_q && !last_q, kind_q == KIND_CMD && pend_q)

endmodule

// File: design/ps2_command_packet_sender_unit.sv
// The first result of an item is written into the job queue and then registered in the output register.
// Throughput: one item per cycle when each gives at most one result and neither in_stall nor out_stall holds;
// a mouse send gives two results, and the output register moves one result per cycle.
// A four-deep job queue sets how far the front end runs ahead of a stalled output.
// Reset: asynchronous; packet state idle, registers to their defaults, store undefined.
module ps2_command_packet_sender_unit
	import ps2cps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       operation,
	input  logic [IDX_W-1:0] byte_index,
	input  logic [7:0]       packet_byte,
	input  logic [4:0]       packet_length,
	input  logic             to_mouse,
	input  logic [7:0]       device_reply,
	input  logic             link_ready,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       result_kind,
	output logic [7:0]       out_byte,
	output logic [2:0]       status,
	output logic             last
);

	logic    accept;
	logic    push;
	logic    q_full;
	logic    q_empty;
	logic    pop;
	job_t    wr_job;
	job_t    rd_job;
	kind_t   kind_w;
	status_t status_w;

	assign in_stall    = q_full;
	assign accept      = in_valid && !q_full;
	assign result_kind = kind_w;
	assign status      = status_w;

	ps2cps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.operation     (operation),
		.byte_index    (byte_index),
		.packet_byte   (packet_byte),
		.packet_length (packet_length),
		.to_mouse      (to_mouse),
		.device_reply  (device_reply),
		.link_ready    (link_ready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.job           (wr_job)
	);

	ps2cps_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && accept),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rd_job (rd_job)
	);

	ps2cps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.rd_job      (rd_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (kind_w),
		.out_byte    (out_byte),
		.status      (status_w),
		.last        (last)
	);

endmodule
